// ===== src/mf8a_pkg.sv =====
package mf8a_pkg;

  localparam int EXP_BIAS  = 4;
  localparam int EXP_MAX   = 7;
  localparam int GRID_BITS = 8;
  localparam int FRAC_W    = 4;
  localparam int EXP_W     = 3;
  localparam int CODE_W    = 8;
  localparam int OPND_W    = 12;  // (16+f) << e, at most 31 << 7
  localparam int MAG_W     = 13;  // sum of two operand magnitudes
  localparam int LEAD_W    = 4;

  // aligned operands, stage 1
  typedef struct packed {
    logic              sign_a;
    logic              sign_b;
    logic [OPND_W-1:0] mag_a;
    logic [OPND_W-1:0] mag_b;
  } align_t;

  // signed magnitude of the exact sum, stage 2
  typedef struct packed {
    logic             sign;
    logic [MAG_W-1:0] mag;
  } sum_t;

  // sum with leading-one position, stage 3
  typedef struct packed {
    logic              sign;
    logic              nonzero;
    logic [LEAD_W-1:0] lead;
    logic [MAG_W-1:0]  mag;
  } lead_t;

  // packed result, stage 4
  typedef struct packed {
    logic [CODE_W-1:0] sum_code;
    logic              overflow_flag;
    logic              zero_flag;
  } result_t;

endpackage

// ===== src/mf8a_if.sv =====
interface mf8a_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] addend_a;
  logic [7:0] addend_b;
  modport source (output valid, output addend_a, output addend_b, input ready);
  modport sink   (input valid, input addend_a, input addend_b, output ready);
endinterface

interface mf8a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sum_code;
  logic       overflow_flag;
  logic       zero_flag;
  modport source (output valid, output sum_code, output overflow_flag,
                  output zero_flag, input ready);
  modport sink   (input valid, input sum_code, input overflow_flag,
                  input zero_flag, output ready);
endinterface

// ===== src/mf8a_sum.sv =====
// Stages 1-2: operand alignment onto the 2^-8 grid, then signed-magnitude add.
module mf8a_sum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [7:0]          addend_a,
  input  logic [7:0]          addend_b,
  output logic                s2_valid,
  output mf8a_pkg::sum_t      s2_data
);

  logic               s1_valid_r;
  mf8a_pkg::align_t   s1_r, s1_nxt;
  logic               s2_valid_r;
  mf8a_pkg::sum_t     s2_r, s2_nxt;

  always_comb begin
    s1_nxt.sign_a = addend_a[7];
    s1_nxt.sign_b = addend_b[7];
    s1_nxt.mag_a  = mf8a_pkg::OPND_W'({1'b1, addend_a[3:0]}) << addend_a[6:4];
    s1_nxt.mag_b  = mf8a_pkg::OPND_W'({1'b1, addend_b[3:0]}) << addend_b[6:4];
  end

  always_comb begin
    if (s1_r.sign_a == s1_r.sign_b) begin
      s2_nxt.sign = s1_r.sign_a;
      s2_nxt.mag  = {1'b0, s1_r.mag_a} + {1'b0, s1_r.mag_b};
    end else if (s1_r.mag_a >= s1_r.mag_b) begin
      s2_nxt.sign = s1_r.sign_a && (s1_r.mag_a != s1_r.mag_b);
      s2_nxt.mag  = {1'b0, s1_r.mag_a - s1_r.mag_b};
    end else begin
      s2_nxt.sign = s1_r.sign_b;
      s2_nxt.mag  = {1'b0, s1_r.mag_b - s1_r.mag_a};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_r;

endmodule

// ===== src/mf8a_norm.sv =====
// Stages 3-4: leading-one search, then normalize, truncate and pack.
module mf8a_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                s2_valid,
  input  mf8a_pkg::sum_t      s2_data,
  output logic                s4_valid,
  output mf8a_pkg::result_t   s4_data
);

  logic                  s3_valid_r;
  mf8a_pkg::lead_t       s3_r, s3_nxt;
  logic                  s4_valid_r;
  mf8a_pkg::result_t     s4_r, s4_nxt;
  logic [mf8a_pkg::MAG_W-1:0] norm_mag;
  logic [mf8a_pkg::LEAD_W-1:0] exp_raw;

  always_comb begin
    s3_nxt.sign    = s2_data.sign;
    s3_nxt.mag     = s2_data.mag;
    s3_nxt.nonzero = |s2_data.mag;
    s3_nxt.lead    = '0;
    for (int i = 0; i < mf8a_pkg::MAG_W; i++) begin
      if (s2_data.mag[i]) s3_nxt.lead = mf8a_pkg::LEAD_W'(i);
    end
  end

  // biased exponent = lead - 4; below zero is underflow, above 7 saturates
  always_comb begin
    exp_raw  = s3_r.lead - mf8a_pkg::LEAD_W'(mf8a_pkg::FRAC_W);
    norm_mag = s3_r.mag >> exp_raw;
    s4_nxt   = '0;
    if (!s3_r.nonzero || s3_r.lead < mf8a_pkg::LEAD_W'(mf8a_pkg::FRAC_W)) begin
      s4_nxt.zero_flag = 1'b1;
    end else if (exp_raw > mf8a_pkg::LEAD_W'(mf8a_pkg::EXP_MAX)) begin
      s4_nxt.overflow_flag = 1'b1;
      s4_nxt.sum_code = {s3_r.sign, mf8a_pkg::EXP_W'(mf8a_pkg::EXP_MAX),
                         norm_mag[mf8a_pkg::FRAC_W-1:0]};
    end else begin
      s4_nxt.sum_code = {s3_r.sign, exp_raw[mf8a_pkg::EXP_W-1:0],
                         norm_mag[mf8a_pkg::FRAC_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign s4_valid = s4_valid_r;
  assign s4_data  = s4_r;

endmodule

// ===== src/minifloat8_adder_core.sv =====
// Eight-bit minifloat adder: sign, 3-bit excess-4 exponent, 4-bit fraction
// with hidden one.
// in_ch: one transfer carries addend_a and addend_b.
// out_ch: one transfer carries sum_code, overflow_flag and zero_flag.
// Four register stages: align, add, leading-one search, normalize/pack.
// out_ch.valid rises once the add has passed all four register stages; one
// add is accepted every cycle while the output register is empty or taken.
// The whole pipeline advances together when the output register is empty
// or being taken; when the receiver stalls every stage holds, in_ch.ready
// drops, and nothing is lost or repeated.
// Sums below 1/16 or exactly zero give code 0 with zero_flag; sums of 16.0
// or more saturate the exponent at 7 with overflow_flag.
// Synchronous reset clears all valid bits; no state carries between adds.
module minifloat8_adder_core (
  input  logic             clk,
  input  logic             rst_n,
  mf8a_in_if.sink          in_ch,
  mf8a_out_if.source       out_ch
);

  logic                 adv;
  logic                 s2_valid;
  mf8a_pkg::sum_t       s2_data;
  logic                 s4_valid;
  mf8a_pkg::result_t    s4_data;

  // stall-all pipeline: move when the output slot is free or leaving
  assign adv         = !s4_valid || out_ch.ready;
  assign in_ch.ready = adv;

  mf8a_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .addend_a (in_ch.addend_a),
    .addend_b (in_ch.addend_b),
    .s2_valid (s2_valid),
    .s2_data  (s2_data)
  );

  mf8a_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s2_valid (s2_valid),
    .s2_data  (s2_data),
    .s4_valid (s4_valid),
    .s4_data  (s4_data)
  );

  assign out_ch.valid         = s4_valid;
  assign out_ch.sum_code      = s4_data.sum_code;
  assign out_ch.overflow_flag = s4_data.overflow_flag;
  assign out_ch.zero_flag     = s4_data.zero_flag;

  // zero result must be the all-zero code
  a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_flag |-> out_ch.sum_code == 8'h00)
    else $error("zero_flag with nonzero code");

  // saturation must pin the exponent field
  a_ovf_exp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.overflow_flag |-> out_ch.sum_code[6:4] == 3'd7)
    else $error("overflow without saturated exponent");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.zero_flag && out_ch.overflow_flag))
    else $error("both flags set");

  // a stalled result must not be replaced by a new one
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(s4_data))
    else $error("result changed under stall");

endmodule

// ===== verif/minifloat8_adder_core_tb.sv =====
module minifloat8_adder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Operand pair for one add.
  typedef struct packed {
    logic [mf8a_pkg::CODE_W-1:0] a;
    logic [mf8a_pkg::CODE_W-1:0] b;
  } add_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mf8a_in_if  in_ch ();
  mf8a_out_if out_ch ();

  minifloat8_adder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  add_req_t           add_q[$];      // adds waiting to be offered
  mf8a_pkg::result_t  sum_exp_q[$];  // expected sums, oldest first
  int       err_cnt = 0;
  bit       stim_done = 1'b0;
  bit       send_hold = 1'b0;  // stimulus side asks the sender to idle
  bit       rx_hold = 1'b0;    // long receiver hold-off
  bit       in_fire = 1'b0;    // input transfer at the last rising edge
  int       burst_left = 0;
  int       gap_left = 0;
  int       stall_phase = 0;

  // Magnitude of one code on the 2^-8 grid, signed.
  function automatic int code_to_grid(logic [mf8a_pkg::CODE_W-1:0] c);
    int m;
    m = (16 + int'(c[mf8a_pkg::FRAC_W-1:0])) << int'(c[6:4]);
    return c[7] ? -m : m;
  endfunction

  // Exact sum, normalized and truncated toward zero.
  function automatic mf8a_pkg::result_t minifloat_sum(logic [mf8a_pkg::CODE_W-1:0] a,
                                                      logic [mf8a_pkg::CODE_W-1:0] b);
    mf8a_pkg::result_t r;
    int      s;
    int      mag;
    int      msb;
    int      e;
    logic    neg;
    s   = code_to_grid(a) + code_to_grid(b);
    neg = (s < 0);
    mag = neg ? -s : s;
    msb = -1;
    for (int i = 0; i < 16; i++)
      if (mag[i]) msb = i;
    e = msb - mf8a_pkg::GRID_BITS + mf8a_pkg::EXP_BIAS;
    r = '0;
    if (msb < 0 || e < 0) begin
      // exact zero or underflow: sign dropped
      r.zero_flag = 1'b1;
    end else begin
      if (e > mf8a_pkg::EXP_MAX) begin
        e = mf8a_pkg::EXP_MAX;
        r.overflow_flag = 1'b1;
      end
      r.sum_code = {neg, e[mf8a_pkg::EXP_W-1:0],
                    4'((mag >> (msb - mf8a_pkg::FRAC_W)) & 'hF)};
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    err_cnt++;
  endtask

  task automatic queue_add(logic [mf8a_pkg::CODE_W-1:0] a, logic [mf8a_pkg::CODE_W-1:0] b);
    add_req_t r;
    r.a = a;
    r.b = b;
    add_q.push_back(r);
  endtask

  initial forever #4 clk = ~clk;

  // Driver: bursts of random length, random gaps; drives at the falling edge.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.addend_a = '0;
    in_ch.addend_b = '0;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      // previous transfer done (or nothing offered): pick the next step
      if (add_q.size() > 0 && !send_hold && gap_left == 0) begin
        in_ch.valid    <= 1'b1;
        in_ch.addend_a <= add_q[0].a;
        in_ch.addend_b <= add_q[0].b;
        add_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Receiver: its own stall pattern, plus a long hold-off on request.
  initial out_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 64;
      if (rx_hold)
        out_ch.ready <= 1'b0;
      else if (stall_phase < 24)
        out_ch.ready <= 1'b1;  // stretch with no stalls
      else
        out_ch.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Transfers are taken at the rising edge: input side books the expectation,
  // output side checks against the oldest one.
  always @(posedge clk) begin
    mf8a_pkg::result_t want;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sum_exp_q.push_back(minifloat_sum(in_ch.addend_a, in_ch.addend_b));
      if (out_ch.valid && out_ch.ready) begin
        if (sum_exp_q.size() == 0) begin
          report_mismatch("unexpected transfer", out_ch.sum_code, 0);
        end else begin
          want = sum_exp_q.pop_front();
          if (out_ch.sum_code !== want.sum_code)
            report_mismatch("sum_code", out_ch.sum_code, want.sum_code);
          if (out_ch.overflow_flag !== want.overflow_flag)
            report_mismatch("overflow_flag", out_ch.overflow_flag, want.overflow_flag);
          if (out_ch.zero_flag !== want.zero_flag)
            report_mismatch("zero_flag", out_ch.zero_flag, want.zero_flag);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    int hold_cnt;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: extremes, exact zero, overflow, sign mix.
    queue_add(8'h00, 8'h00);  // smallest + smallest = 0.125
    queue_add(8'h7F, 8'h7F);  // largest + largest -> overflow
    queue_add(8'hFF, 8'hFF);  // negative overflow keeps sign
    queue_add(8'h7F, 8'hFF);  // exact zero
    queue_add(8'h00, 8'h80);  // exact zero, smallest
    queue_add(8'h40, 8'h40);  // 1 + 1
    queue_add(8'h40, 8'hC0);
    queue_add(8'h4F, 8'hC0);  // difference with cancellation
    queue_add(8'h70, 8'h00);
    queue_add(8'hF0, 8'h00);
    queue_add(8'h3F, 8'h00);  // just crosses 1.0
    queue_add(8'h7F, 8'h80);
    queue_add(8'h55, 8'hAA);
    queue_add(8'hAA, 8'h55);
    queue_add(8'h01, 8'hFE);
    queue_add(8'h70, 8'h70);  // 16.0 -> overflow, fraction 0
    queue_add(8'h6F, 8'h6F);
    queue_add(8'hC8, 8'h48);
    queue_add(8'h30, 8'h30);  // 0.5 + 0.5 = 1.0
    queue_add(8'hB0, 8'hB0);

    // Random, first batch.
    for (int i = 0; i < 600; i++) begin
      if ($urandom_range(0, 3) == 0)
        queue_add(8'($urandom), {1'b1, 7'($urandom)});
      else
        queue_add(8'($urandom), 8'($urandom));
    end

    // Long receiver hold-off while the sender keeps offering.
    wait (add_q.size() < 550);
    rx_hold = 1'b1;
    hold_cnt = 0;
    while (hold_cnt < 60) begin
      @(posedge clk);
      hold_cnt++;
    end
    rx_hold = 1'b0;

    // Sender pauses until every expected sum has come.
    wait (add_q.size() == 0);
    send_hold = 1'b1;
    wait (sum_exp_q.size() == 0 && !in_ch.valid);
    send_hold = 1'b0;

    // Random, second batch: near-cancelling pairs mixed in.
    for (int i = 0; i < 1130; i++) begin
      logic [mf8a_pkg::CODE_W-1:0] a;
      a = 8'($urandom);
      if ($urandom_range(0, 4) == 0)
        queue_add(a, {~a[7], a[6:4], 4'($urandom)});
      else
        queue_add(a, 8'($urandom));
    end

    wait (add_q.size() == 0 && !in_ch.valid);
    wait (sum_exp_q.size() == 0);
    repeat (10) @(posedge clk);
    if (sum_exp_q.size() != 0)
      report_mismatch("results left over", sum_exp_q.size(), 0);
    if (err_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule
